### design/move_to_front_list_search_assert.svh
// assertion macros shared by the move-to-front list checker
`ifndef MOVE_TO_FRONT_LIST_SEARCH_ASSERT_SVH
`define MOVE_TO_FRONT_LIST_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MTFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MTFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mtfl_pkg.sv
// types and constants of the move-to-front list search block
`timescale 1ns / 1ps

package mtfl_pkg;

  localparam int DATA_W = 32;
  localparam int POS_OUT_W = 4;

  typedef enum logic [1:0] {
    ACT_CLEAR      = 2'd0,
    ACT_APPEND     = 2'd1,
    ACT_SEARCH     = 2'd2,
    ACT_SEARCH_MTF = 2'd3
  } mtfl_action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } mtfl_state_t;

  typedef struct packed {
    mtfl_action_t              action;
    logic signed [DATA_W-1:0]  item_value;
  } mtfl_in_t;

  typedef struct packed {
    logic                  found;
    logic [POS_OUT_W-1:0]  match_position;
    logic                  full_error;
  } mtfl_out_t;

  // global controls from the sequencer
  typedef struct packed {
    logic cmp;
    logic app;
    logic mtf;
  } mtfl_ctl_t;

  // per-cell command
  typedef struct packed {
    logic cmp;
    logic app;
    logic mtf;
  } mtfl_cell_cmd_t;

endpackage

### design/move_to_front_list_search.sv
// Move-to-front list search: a row of DEPTH cells, one entry each.
// The request is compared as it is accepted, then the execute state updates
// the cells and registers the result; the first-match and shift chain across
// the cells sets the update step. New requests are taken only after it ends.
// Reset: synchronous, clears the entry count and handshake state; entries
// are not cleared and are only read once written.
`timescale 1ns / 1ps

module move_to_front_list_search #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mtfl_pkg::mtfl_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mtfl_pkg::mtfl_out_t   out_data
);
  import mtfl_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (IDX_W > POS_OUT_W) ? IDX_W : POS_OUT_W;

  mtfl_ctl_t                ctl;
  logic signed [DATA_W-1:0] key;
  logic [CNT_W-1:0]         count;
  logic [DEPTH:0]           before_w;
  logic signed [DATA_W-1:0] hit_w [DEPTH+1];
  logic signed [DATA_W-1:0] val_w [DEPTH];
  logic [DEPTH-1:0]         first_w;
  logic [POS_W-1:0]         pos;
  logic                     any_hit;

  assign before_w[0] = 1'b0;
  assign hit_w[0]    = '0;
  assign any_hit     = before_w[DEPTH];

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mtfl_cell_cmd_t           cmd;
    logic signed [DATA_W-1:0] left;

    assign cmd.cmp = ctl.cmp;
    assign cmd.app = ctl.app && (count == CNT_W'(i));
    assign cmd.mtf = ctl.mtf && any_hit;
    assign left    = (i == 0) ? hit_w[DEPTH] : val_w[(i == 0) ? 0 : i - 1];
    assign first_w[i] = before_w[i+1] && !before_w[i];

    mtfl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (CNT_W'(i) < count),
      .cmp_key    (in_data.item_value),
      .app_key    (key),
      .left_in    (left),
      .before_in  (before_w[i]),
      .before_out (before_w[i+1]),
      .hit_in     (hit_w[i]),
      .hit_out    (hit_w[i+1]),
      .value_out  (val_w[i])
    );
  end

  // encode the first-match position
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_w[i]) pos = pos | POS_W'(i);
    end
  end

  mtfl_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .any_hit   (any_hit),
    .hit_pos   (pos[POS_OUT_W-1:0]),
    .ctl       (ctl),
    .key       (key),
    .count     (count)
  );

endmodule

### design/mtfl_cell.sv
// one list cell: holds an entry, compares it with the key, shifts from its neighbor
`timescale 1ns / 1ps

module mtfl_cell (
  input  logic                                   clk,
  input  mtfl_pkg::mtfl_cell_cmd_t               cmd,
  input  logic                                   valid,
  input  logic signed [mtfl_pkg::DATA_W-1:0]     cmp_key,
  input  logic signed [mtfl_pkg::DATA_W-1:0]     app_key,
  input  logic signed [mtfl_pkg::DATA_W-1:0]     left_in,
  input  logic                                   before_in,
  output logic                                   before_out,
  input  logic signed [mtfl_pkg::DATA_W-1:0]     hit_in,
  output logic signed [mtfl_pkg::DATA_W-1:0]     hit_out,
  output logic signed [mtfl_pkg::DATA_W-1:0]     value_out
);
  import mtfl_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic                     match_r;
  logic                     first;

  // compare against the request key
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      match_r <= valid && (value_r == cmp_key);
    end
  end

  // first-match chain toward the tail
  assign first      = match_r && !before_in;
  assign before_out = before_in || match_r;
  assign hit_out    = first ? value_r : hit_in;

  // append load, or shift back by one up to the first match
  always_ff @(posedge clk) begin
    if (cmd.app) begin
      value_r <= app_key;
    end else if (cmd.mtf && !before_in) begin
      value_r <= left_in;
    end
  end

  assign value_out = value_r;

endmodule

### design/mtfl_ctrl.sv
// sequencer: handshake, entry count and result register
`timescale 1ns / 1ps

module mtfl_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mtfl_pkg::mtfl_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mtfl_pkg::mtfl_out_t                 out_data,
  input  logic                                any_hit,
  input  logic [mtfl_pkg::POS_OUT_W-1:0]      hit_pos,
  output mtfl_pkg::mtfl_ctl_t                 ctl,
  output logic signed [mtfl_pkg::DATA_W-1:0]  key,
  output logic [CNT_W-1:0]                    count
);
  import mtfl_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mtfl_state_t              state_r, state_nxt;
  mtfl_action_t             action_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mtfl_out_t                out_r, out_nxt;
  logic                     accept;
  logic                     exec;
  logic                     is_full;

  assign is_full = (count_r == FULL_CNT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    exec     = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = !out_valid_r || out_ready;
      ST_EXEC: exec = 1'b1;
      default: begin
        in_ready = 1'b0;
        exec     = 1'b0;
      end
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign ctl.cmp = accept;
  assign ctl.app = exec && (action_r == ACT_APPEND) && !is_full;
  assign ctl.mtf = exec && (action_r == ACT_SEARCH_MTF);

  // count and result
  always_comb begin
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (exec) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      case (action_r)
        ACT_CLEAR: count_nxt = '0;
        ACT_APPEND: begin
          if (is_full) out_nxt.full_error = 1'b1;
          else count_nxt = count_r + CNT_W'(1);
        end
        ACT_SEARCH, ACT_SEARCH_MTF: begin
          out_nxt.found          = any_hit;
          out_nxt.match_position = hit_pos;
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      action_r <= in_data.action;
      key_r    <= in_data.item_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign key       = key_r;
  assign count     = count_r;

endmodule

### design/mtfl_checker.sv
// port-level checker for the move-to-front list search block, with its bind
`timescale 1ns / 1ps
`include "move_to_front_list_search_assert.svh"

module mtfl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input mtfl_pkg::mtfl_in_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input mtfl_pkg::mtfl_out_t  out_data
);
  import mtfl_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // a stalled result holds
  `MTFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  // a request is taken only with the result slot free, so none shows next cycle
  `MTFL_ASSERT_NEXT(a_slot_free, in_acc, !out_valid && !in_ready, "result slot busy after request")
  // every request gives its result once its execute state has passed
  `MTFL_ASSERT_NOW(a_latency, in_acc, ##2 out_valid, "result missing two cycles after request")
  // a search hit never reports a dropped append
  `MTFL_ASSERT_NOW(a_excl, out_valid && out_data.found, !out_data.full_error, "found and full both set")

endmodule

bind move_to_front_list_search mtfl_checker u_mtfl_checker (.*);

### dv/tb_top.sv
// self-checking testbench for the move-to-front list search block
`timescale 1ns / 1ps

module tb_top;
  import mtfl_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int TOTAL_REQS = 1475;
  localparam int CALM_TAIL = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mtfl_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mtfl_out_t out_data;

  // requests waiting to be driven and results still owed by the block
  mtfl_in_t pending_requests[$];
  mtfl_out_t expected_results[$];

  // shadow copy of the list contents
  logic [DATA_W-1:0] shadow_list[LIST_DEPTH];
  int shadow_count = 0;

  int mismatch_count = 0;
  int in_gap_left = 0;
  int in_gap_pct = 0;
  int in_mode_left = 0;
  int out_stall_left = 0;
  int out_stall_pct = 0;
  int out_mode_left = 0;

  move_to_front_list_search #(.DEPTH(LIST_DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one request to the shadow list and return the result it owes
  function automatic mtfl_out_t list_op_result(mtfl_in_t req);
    mtfl_out_t res;
    int hit;
    logic [DATA_W-1:0] moved;
    res = '0;
    hit = -1;
    case (req.action)
      ACT_CLEAR: shadow_count = 0;
      ACT_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          res.full_error = 1'b1;
        end else begin
          shadow_list[shadow_count] = req.item_value;
          shadow_count++;
        end
      end
      default: begin
        // first match from the head wins
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_list[i] == req.item_value) hit = i;
        end
        if (hit >= 0) begin
          res.found = 1'b1;
          res.match_position = hit[POS_OUT_W-1:0];
          if (req.action == ACT_SEARCH_MTF) begin
            moved = shadow_list[hit];
            for (int i = hit; i > 0; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[0] = moved;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic queue_request(mtfl_action_t act, logic [DATA_W-1:0] value);
    mtfl_in_t req;
    req.action = act;
    req.item_value = value;
    pending_requests.push_back(req);
  endtask

  function automatic logic [DATA_W-1:0] extreme_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'h0000_0000;
      default: v = 32'hffff_ffff;
    endcase
    return v;
  endfunction

  // request driver: idle bursts only between requests, none near the end
  always @(posedge clk) begin
    mtfl_in_t next_data;
    logic next_valid;
    next_valid = in_valid;
    next_data = in_data;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(list_op_result(in_data));
      if (!in_valid || in_ready) begin
        next_valid = 1'b0;
        if (in_mode_left == 0) begin
          case ($urandom_range(0, 2))
            0: in_gap_pct = 0;
            1: in_gap_pct = 15;
            default: in_gap_pct = 50;
          endcase
          in_mode_left = $urandom_range(20, 80);
        end else begin
          in_mode_left--;
        end
        if (in_gap_left != 0) begin
          in_gap_left--;
        end else if (pending_requests.size() > CALM_TAIL &&
                     $urandom_range(0, 99) < in_gap_pct) begin
          in_gap_left = $urandom_range(1, 15) - 1;
        end else if (pending_requests.size() != 0) begin
          next_valid = 1'b1;
          next_data = pending_requests.pop_front();
        end
      end
    end
    in_valid <= next_valid;
    in_data <= next_data;
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    mtfl_out_t want;
    logic next_ready;
    next_ready = 1'b1;
    if (!rst_n) begin
      next_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: expected none, ",
                   $time,
                   "actual found=%0b pos=%0d full=%0b",
                   out_data.found, out_data.match_position, out_data.full_error);
        end else begin
          want = expected_results.pop_front();
          if (out_data.found !== want.found ||
              out_data.match_position !== want.match_position ||
              out_data.full_error !== want.full_error) begin
            mismatch_count++;
            $display("%0t mismatch: expected found=%0b pos=%0d full=%0b, ",
                     $time, want.found, want.match_position, want.full_error,
                     "actual found=%0b pos=%0d full=%0b",
                     out_data.found, out_data.match_position, out_data.full_error);
          end
        end
      end
      if (out_mode_left == 0) begin
        case ($urandom_range(0, 2))
          0: out_stall_pct = 0;
          1: out_stall_pct = 15;
          default: out_stall_pct = 50;
        endcase
        out_mode_left = $urandom_range(20, 80);
      end else begin
        out_mode_left--;
      end
      if (out_stall_left != 0) begin
        out_stall_left--;
        next_ready = 1'b0;
      end else if (pending_requests.size() > CALM_TAIL &&
                   $urandom_range(0, 99) < out_stall_pct) begin
        out_stall_left = $urandom_range(1, 15) - 1;
        next_ready = 1'b0;
      end
    end
    out_ready <= next_ready;
  end

  // stimulus, reset and end of run
  initial begin
    logic [DATA_W-1:0] value_pool[8];
    int n_append;
    int n_query;
    int pick;
    logic [DATA_W-1:0] key;

    // directed: empty list, extremes, duplicates, head and mid moves
    queue_request(ACT_CLEAR, 32'h0);
    queue_request(ACT_SEARCH, 32'h5);
    queue_request(ACT_APPEND, 32'h8000_0000);
    queue_request(ACT_APPEND, 32'h7fff_ffff);
    queue_request(ACT_APPEND, 32'h0000_0000);
    queue_request(ACT_APPEND, 32'hffff_ffff);
    queue_request(ACT_APPEND, 32'h7fff_ffff);
    queue_request(ACT_SEARCH, 32'h7fff_ffff);
    queue_request(ACT_SEARCH, 32'h5);
    queue_request(ACT_SEARCH_MTF, 32'hffff_ffff);
    queue_request(ACT_SEARCH_MTF, 32'hffff_ffff);
    queue_request(ACT_SEARCH_MTF, 32'h7fff_ffff);
    queue_request(ACT_SEARCH, 32'h0000_0000);
    // fill to the last slot, overflow, then move the tail entry
    repeat (10) queue_request(ACT_APPEND, $urandom);
    queue_request(ACT_APPEND, 32'h1234_5678);
    queue_request(ACT_APPEND, 32'hdead_beef);
    queue_request(ACT_SEARCH_MTF, 32'h1234_5678);

    // random: fill then query, keys mostly drawn from a small pool
    while (pending_requests.size() < TOTAL_REQS) begin
      for (int k = 0; k < 8; k++)
        value_pool[k] = ($urandom_range(0, 9) == 0) ? extreme_value() : $urandom;
      if ($urandom_range(0, 4) != 0) queue_request(ACT_CLEAR, $urandom);
      n_append = $urandom_range(0, 20);
      repeat (n_append) queue_request(ACT_APPEND, value_pool[$urandom_range(0, 7)]);
      n_query = $urandom_range(4, 20);
      repeat (n_query) begin
        key = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, 7)] : $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 8) queue_request(ACT_SEARCH, key);
        else if (pick < 16) queue_request(ACT_SEARCH_MTF, key);
        else if (pick < 19) queue_request(ACT_APPEND, key);
        else queue_request(ACT_CLEAR, key);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    // every owed result must have come back
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mtfl_pkg.sv
design/mtfl_cell.sv
design/mtfl_ctrl.sv
design/move_to_front_list_search.sv
design/mtfl_checker.sv
dv/tb_top.sv
